### hdl/msxcp_pkg.sv
// ----------------------------------------------------------------------------
// msxcp_pkg
// Shared types, constants and reply byte tables for the SysEx command parser.
// ----------------------------------------------------------------------------
package msxcp_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 7;
    localparam int unsigned IDX_W      = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_BYTE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISACK_BYTE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVALID_ARG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COLOURS  = 3'd6;

    // protocol bytes
    localparam logic [7:0] SYX_START = 8'hF0;
    localparam logic [7:0] SYX_END   = 8'hF7;
    localparam logic [7:0] MFR_ID0   = 8'h00;
    localparam logic [7:0] MFR_ID1   = 8'h00;
    localparam logic [7:0] MFR_ID2   = 8'h7E;
    localparam logic [7:0] DEV_TYPE  = 8'h4E;
    localparam logic [7:0] BODY_ONE  = 8'h01;
    localparam logic [7:0] BODY_ZERO = 8'h00;

    localparam logic [2:0] HDR_LEN = 3'd5;

    // commands
    localparam logic [6:0] CMD_LAYOUT   = 7'h00;
    localparam logic [6:0] CMD_IGNORE_A = 7'h01;
    localparam logic [6:0] CMD_IGNORE_B = 7'h0E;
    localparam logic [6:0] CMD_ACK      = 7'h0F;

    // reply lengths, as index of the closing byte
    localparam logic [IDX_W-1:0] LAYOUT_LAST = 4'd13;
    localparam logic [IDX_W-1:0] ACK_LAST    = 4'd8;

    typedef enum logic [1:0] {
        RPL_LAYOUT = 2'd0,
        RPL_ACK    = 2'd1,
        RPL_DISACK = 2'd2
    } reply_kind_t;

    typedef struct packed {
        logic [6:0] device_id;
        logic [6:0] ack_byte;
        logic [6:0] disack_byte;
        logic [6:0] invalid_command_arg;
        logic [6:0] grid_columns;
        logic [6:0] grid_rows;
        logic [6:0] led_colours;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        reply_kind_t kind;
        logic [7:0]  port;
    } reply_req_t;

    function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0:    b = SYX_START;
            3'd1:    b = MFR_ID0;
            3'd2:    b = MFR_ID1;
            3'd3:    b = MFR_ID2;
            3'd4:    b = DEV_TYPE;
            default: b = BODY_ZERO;
        endcase
        return b;
    endfunction

    function automatic logic [IDX_W-1:0] reply_last(input reply_kind_t kind);
        return (kind == RPL_LAYOUT) ? LAYOUT_LAST : ACK_LAST;
    endfunction

    function automatic logic [7:0] reply_byte(input reply_kind_t kind,
                                              input logic [IDX_W-1:0] idx,
                                              input cfg_t cfg);
        logic [7:0] b;
        b = BODY_ZERO;
        if (idx < 4'd5) begin
            b = hdr_byte(idx[2:0]);
        end else if (idx == 4'd5) begin
            b = {1'b0, cfg.device_id};
        end else if (idx == reply_last(kind)) begin
            b = SYX_END;
        end else begin
            case (kind)
                RPL_LAYOUT:
                begin
                    case (idx)
                        4'd7:    b = {1'b0, cfg.grid_columns};
                        4'd8:    b = {1'b0, cfg.grid_rows};
                        4'd9:    b = {1'b0, cfg.led_colours};
                        default: b = BODY_ONE;
                    endcase
                end
                RPL_ACK:
                begin
                    b = (idx == 4'd6) ? {1'b0, cfg.ack_byte} : BODY_ZERO;
                end
                RPL_DISACK:
                begin
                    b = (idx == 4'd6) ? {1'b0, cfg.disack_byte}
                                      : {1'b0, cfg.invalid_command_arg};
                end
                default: b = BODY_ZERO;
            endcase
        end
        return b;
    endfunction

endpackage

### hdl/msxcp_cfg_regs.sv
// ----------------------------------------------------------------------------
// msxcp_cfg_regs
// Configuration register bank with write-only indexed access.
// ----------------------------------------------------------------------------
module msxcp_cfg_regs
    import msxcp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_DEVICE_ID:    cfg_next.device_id           = cfg_data;
                CFG_ACK_BYTE:     cfg_next.ack_byte            = cfg_data;
                CFG_DISACK_BYTE:  cfg_next.disack_byte         = cfg_data;
                CFG_INVALID_ARG:  cfg_next.invalid_command_arg = cfg_data;
                CFG_GRID_COLUMNS: cfg_next.grid_columns        = cfg_data;
                CFG_GRID_ROWS:    cfg_next.grid_rows           = cfg_data;
                CFG_LED_COLOURS:  cfg_next.led_colours         = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.device_id           <= 7'd0;
            cfg_reg.ack_byte            <= 7'd15;
            cfg_reg.disack_byte         <= 7'd14;
            cfg_reg.invalid_command_arg <= 7'd12;
            cfg_reg.grid_columns        <= 7'd16;
            cfg_reg.grid_rows           <= 7'd16;
            cfg_reg.led_colours         <= 7'd2;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/msxcp_parser.sv
// ----------------------------------------------------------------------------
// msxcp_parser
// Header matcher and command decoder; issues a reply request for transfers that call for one.
// ----------------------------------------------------------------------------
module msxcp_parser
    import msxcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] port,
    input  logic [7:0] data_byte,
    input  cfg_t       cfg,
    output reply_req_t req
);

    logic [2:0] header_count_reg, header_count_next;
    logic       in_message_reg, in_message_next;
    logic       have_command_reg, have_command_next;
    logic [6:0] command_byte_reg, command_byte_next;
    logic [7:0] owner_port_reg, owner_port_next;

    logic       bad;
    logic [2:0] hc_inc;
    logic [6:0] cmd_eff;
    logic       cmd_known;

    always_comb
    begin
        header_count_next = header_count_reg;
        in_message_next   = in_message_reg;
        have_command_next = have_command_reg;
        command_byte_next = command_byte_reg;
        owner_port_next   = owner_port_reg;
        req.valid         = 1'b0;
        req.kind          = RPL_ACK;
        req.port          = port;

        bad = (header_count_reg < HDR_LEN && data_byte != hdr_byte(header_count_reg)) ||
              (header_count_reg == HDR_LEN && data_byte != {1'b0, cfg.device_id});
        hc_inc  = header_count_reg + 3'd1;
        cmd_eff = have_command_reg ? command_byte_reg : data_byte[6:0];
        cmd_known = (cmd_eff == CMD_LAYOUT) || (cmd_eff == CMD_IGNORE_A) ||
                    (cmd_eff == CMD_IGNORE_B) || (cmd_eff == CMD_ACK);

        // drop bytes from foreign ports while a message is open
        if (accept && !(in_message_reg && port != owner_port_reg)) begin
            owner_port_next = port;
            if (!in_message_reg) begin
                if (bad) begin
                    header_count_next = 3'd0;
                    have_command_next = 1'b0;
                    command_byte_next = 7'd0;
                end else begin
                    header_count_next = hc_inc;
                    if (hc_inc > HDR_LEN) begin
                        in_message_next = 1'b1;
                    end
                end
            end else if (data_byte[7]) begin
                if (data_byte == SYX_END && have_command_reg) begin
                    if (command_byte_reg == CMD_LAYOUT) begin
                        req.valid = 1'b1;
                        req.kind  = RPL_LAYOUT;
                    end else if (command_byte_reg == CMD_ACK) begin
                        req.valid = 1'b1;
                        req.kind  = RPL_ACK;
                    end else if (command_byte_reg != CMD_IGNORE_A &&
                                 command_byte_reg != CMD_IGNORE_B) begin
                        req.valid = 1'b1;
                        req.kind  = RPL_DISACK;
                    end
                end
                header_count_next = 3'd0;
                in_message_next   = 1'b0;
                have_command_next = 1'b0;
                command_byte_next = 7'd0;
            end else begin
                have_command_next = 1'b1;
                command_byte_next = cmd_eff;
                if (!cmd_known) begin
                    req.valid         = 1'b1;
                    req.kind          = RPL_DISACK;
                    header_count_next = 3'd0;
                    in_message_next   = 1'b0;
                    have_command_next = 1'b0;
                    command_byte_next = 7'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            header_count_reg <= 3'd0;
            in_message_reg   <= 1'b0;
            have_command_reg <= 1'b0;
            command_byte_reg <= 7'd0;
            owner_port_reg   <= 8'd0;
        end else begin
            header_count_reg <= header_count_next;
            in_message_reg   <= in_message_next;
            have_command_reg <= have_command_next;
            command_byte_reg <= command_byte_next;
            owner_port_reg   <= owner_port_next;
        end
    end

endmodule

### hdl/msxcp_reply.sv
// ----------------------------------------------------------------------------
// msxcp_reply
// Reply serializer feeding a registered output stage, one byte per transfer.
// ----------------------------------------------------------------------------
module msxcp_reply
    import msxcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  reply_req_t req,
    input  cfg_t       cfg,
    output logic       busy,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_port,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic             active_reg, active_next;
    reply_kind_t      kind_reg, kind_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       port_reg, port_next;

    logic       valid_reg, valid_next;
    logic [7:0] oport_reg, oport_next;
    logic [7:0] obyte_reg, obyte_next;
    logic       olast_reg, olast_next;

    logic slot_free;
    logic is_last;

    always_comb
    begin
        active_next = active_reg;
        kind_next   = kind_reg;
        idx_next    = idx_reg;
        port_next   = port_reg;
        valid_next  = valid_reg;
        oport_next  = oport_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;

        slot_free = !valid_reg || out_ready;
        is_last   = (idx_reg == reply_last(kind_reg));

        if (slot_free) begin
            valid_next = 1'b0;
        end

        if (active_reg) begin
            // advance one reply byte into the output stage when it has room
            if (slot_free) begin
                valid_next = 1'b1;
                oport_next = port_reg;
                obyte_next = reply_byte(kind_reg, idx_reg, cfg);
                olast_next = is_last;
                idx_next   = idx_reg + 4'd1;
                if (is_last) begin
                    active_next = 1'b0;
                end
            end
        end else if (req.valid) begin
            active_next = 1'b1;
            kind_next   = req.kind;
            port_next   = req.port;
            idx_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        idx_reg   <= idx_next;
        port_reg  <= port_next;
        oport_reg <= oport_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign busy      = active_reg;
    assign out_valid = valid_reg;
    assign out_port  = oport_reg;
    assign out_byte  = obyte_reg;
    assign out_last  = olast_reg;

endmodule

### hdl/midi_sysex_command_parser_top.sv
// ----------------------------------------------------------------------------
// midi_sysex_command_parser_top
// SysEx command parser with layout-info, ack and disack reply generation.
// ----------------------------------------------------------------------------
// Incoming MIDI bytes, each tagged with its port, are matched against the
// SysEx header F0 00 00 7E 4E followed by the configured device ID. After the
// header the message belongs to the port of its last header byte; bytes from
// other ports are dropped. The first data byte is the command; a status byte
// closes the message. On F7, command 00 answers with a 14-byte layout-info
// reply and command 0F with a 9-byte ack; commands 01 and 0E are silent; any
// other command answers at once with a 9-byte disack. A byte that causes no
// reply is taken without a stall, back to back, even while the last reply byte
// still waits in the output register. A byte that causes a reply holds s_tready
// low while the serializer pushes the reply through the output register, one
// byte per cycle while m_tready is high. Configuration is to be written through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module midi_sysex_command_parser_top
    import msxcp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [7:0] port, [15:8] data_byte
    // reply stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [7:0] out_port, [15:8] out_byte
    output logic                  m_tlast    // last_byte
);

    cfg_t       cfg;
    reply_req_t req;
    logic       busy;
    logic       accept;
    logic [7:0] out_port;
    logic [7:0] out_byte;

    // hold input off while a reply is being serialized
    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;

    msxcp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msxcp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .port      (s_tdata[7:0]),
        .data_byte (s_tdata[15:8]),
        .cfg       (cfg),
        .req       (req)
    );

    msxcp_reply u_reply (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .busy      (busy),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_port  (out_port),
        .out_byte  (out_byte),
        .out_last  (m_tlast)
    );

    assign m_tdata = {out_byte, out_port};

endmodule
